// File: hw/rtl/pbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared types, codes and helpers of the pixel blend raster-operation core.
// ----------------------------------------------------------------------------
package pbr_pkg;

    localparam int NUM_LANES  = 4;
    localparam int LANE_ALPHA = 3;

    // Configuration register indexes
    localparam logic [2:0] REG_BLEND_ENABLE     = 3'd0;
    localparam logic [2:0] REG_WRITE_MASK       = 3'd1;
    localparam logic [2:0] REG_RGB_SRC_WEIGHT   = 3'd2;
    localparam logic [2:0] REG_RGB_DST_WEIGHT   = 3'd3;
    localparam logic [2:0] REG_ALPHA_SRC_WEIGHT = 3'd4;
    localparam logic [2:0] REG_ALPHA_DST_WEIGHT = 3'd5;
    localparam logic [2:0] REG_RGB_EQUATION     = 3'd6;
    localparam logic [2:0] REG_ALPHA_EQUATION   = 3'd7;

    // Weight codes
    localparam logic [3:0] WGT_ZERO          = 4'd0;
    localparam logic [3:0] WGT_ONE           = 4'd1;
    localparam logic [3:0] WGT_SRC_ALPHA_SAT = 4'd2;
    localparam logic [3:0] WGT_DST           = 4'd3;
    localparam logic [3:0] WGT_INV_DST       = 4'd4;
    localparam logic [3:0] WGT_DST_ALPHA     = 4'd5;
    localparam logic [3:0] WGT_INV_DST_ALPHA = 4'd6;
    localparam logic [3:0] WGT_SRC           = 4'd7;
    localparam logic [3:0] WGT_INV_SRC       = 4'd8;
    localparam logic [3:0] WGT_SRC_ALPHA     = 4'd9;
    localparam logic [3:0] WGT_INV_SRC_ALPHA = 4'd10;

    // Equation codes
    localparam logic [1:0] EQ_ADD     = 2'd0;
    localparam logic [1:0] EQ_SUB     = 2'd1;
    localparam logic [1:0] EQ_REV_SUB = 2'd2;

    localparam logic [7:0]  UNORM_ONE  = 8'd255;
    localparam logic [15:0] ROUND_BIAS = 16'd127;
    // Smallest product sum that rounds above full scale
    localparam logic [16:0] SAT_LIMIT  = 17'd65153;

    typedef struct packed {
        logic [3:0] src_weight;
        logic [3:0] dst_weight;
        logic [1:0] equation;
    } lane_cfg_t;

    typedef struct packed {
        logic adv_a;
        logic adv_b;
    } lane_ctrl_t;

    function automatic logic [7:0] blend_factor(
        input logic [3:0] code,
        input logic [7:0] s,
        input logic [7:0] d,
        input logic [7:0] sa,
        input logic [7:0] da
    );
        logic [7:0] inv_da;
        logic [7:0] f;
        inv_da = UNORM_ONE - da;
        unique case (code)
            WGT_ZERO:          f = 8'd0;
            WGT_SRC_ALPHA_SAT: f = (inv_da < sa) ? inv_da : sa;
            WGT_DST:           f = d;
            WGT_INV_DST:       f = UNORM_ONE - d;
            WGT_DST_ALPHA:     f = da;
            WGT_INV_DST_ALPHA: f = inv_da;
            WGT_SRC:           f = s;
            WGT_INV_SRC:       f = UNORM_ONE - s;
            WGT_SRC_ALPHA:     f = sa;
            WGT_INV_SRC_ALPHA: f = UNORM_ONE - sa;
            default:           f = UNORM_ONE;
        endcase
        return f;
    endfunction

endpackage

// File: hw/rtl/pbr_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_lane
// One channel of the blend: factor select and products, then equation,
// rounding to unorm8 and clamp. Two register stages.
// ----------------------------------------------------------------------------
module pbr_lane (
    input  logic               aclk,
    input  pbr_pkg::lane_ctrl_t ctrl,
    input  pbr_pkg::lane_cfg_t  cfg,
    input  logic [7:0]         src,
    input  logic [7:0]         dst,
    input  logic [7:0]         src_alpha,
    input  logic [7:0]         dst_alpha,
    output logic [7:0]         result,
    output logic [7:0]         dst_out
);
    import pbr_pkg::*;

    logic [7:0]  fs;
    logic [7:0]  fd;
    logic [15:0] ts_reg;
    logic [15:0] ts_next;
    logic [15:0] td_reg;
    logic [15:0] td_next;
    logic [7:0]  dst_a_reg;
    logic [7:0]  res_reg;
    logic [7:0]  res_next;
    logic [7:0]  dst_b_reg;

    logic signed [17:0] t;
    logic [15:0]        x;
    logic [16:0]        q;

    assign fs      = blend_factor(cfg.src_weight, src, dst, src_alpha, dst_alpha);
    assign fd      = blend_factor(cfg.dst_weight, src, dst, src_alpha, dst_alpha);
    assign ts_next = fs * src;
    assign td_next = fd * dst;

    always_ff @(posedge aclk) begin
        if (ctrl.adv_a) begin
            ts_reg    <= ts_next;
            td_reg    <= td_next;
            dst_a_reg <= dst;
        end
    end

    always_comb begin
        unique case (cfg.equation)
            EQ_SUB:     t = $signed({2'b00, ts_reg}) - $signed({2'b00, td_reg});
            EQ_REV_SUB: t = $signed({2'b00, td_reg}) - $signed({2'b00, ts_reg});
            default:    t = $signed({2'b00, ts_reg}) + $signed({2'b00, td_reg});
        endcase
        // Round t/255 to nearest: divide by 255 as x + x/256 + 1, shifted by 8
        x = t[15:0] + ROUND_BIAS;
        q = ({1'b0, x} + {9'd0, x[15:8]} + 17'd1) >> 8;
        priority if (t <= 18'sd0) begin
            res_next = 8'd0;
        end else if (t[16:0] >= SAT_LIMIT) begin
            res_next = UNORM_ONE;
        end else begin
            res_next = q[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv_b) begin
            res_reg   <= res_next;
            dst_b_reg <= dst_a_reg;
        end
    end

    assign result  = res_reg;
    assign dst_out = dst_b_reg;

endmodule

// File: hw/rtl/pbr_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_merge
// Combine lane results with the old destination under the write mask and
// hold the finished pixel in the output register.
// ----------------------------------------------------------------------------
module pbr_merge (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  logic                            in_valid,
    input  logic [pbr_pkg::NUM_LANES-1:0]   write_mask,
    input  logic [pbr_pkg::NUM_LANES*8-1:0] lane_result,
    input  logic [pbr_pkg::NUM_LANES*8-1:0] lane_dst,
    output logic                            out_valid,
    output logic [pbr_pkg::NUM_LANES*8-1:0] out_pixel
);
    import pbr_pkg::*;

    logic                     valid_reg;
    logic [NUM_LANES*8-1:0]   pixel_reg;
    logic [NUM_LANES*8-1:0]   pixel_next;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            pixel_next[i*8 +: 8] = write_mask[i] ? lane_result[i*8 +: 8]
                                                 : lane_dst[i*8 +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

// File: hw/rtl/pixel_blend_rop_core.sv
`timescale 1ns / 1ps
// Registers in order: products, equation and rounding, masked merge into
// the output register. Throughput: one pixel per cycle while m_tready is
// high; four channel lanes work side by side and every stage advances on
// its own, so bubbles collapse under backpressure.
// Reset: aresetn (synchronous, active low) empties the pipeline and loads
// the configuration defaults (blend off, all channels writable).
// ----------------------------------------------------------------------------
// pixel_blend_rop_core
// Raster-operation blend of an RGBA8 source onto an ARGB8888 destination.
// ----------------------------------------------------------------------------
module pixel_blend_rop_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // src_red[7:0], src_green[15:8], src_blue[23:16], src_alpha[31:24],
    // dst_pixel[63:32]
    input  logic [63:0] s_tdata,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // new_pixel[31:0]
    output logic [31:0] m_tdata
);
    import pbr_pkg::*;

    logic       blend_enable_reg;
    logic [3:0] write_mask_reg;
    logic [3:0] rgb_src_weight_reg;
    logic [3:0] rgb_dst_weight_reg;
    logic [3:0] alpha_src_weight_reg;
    logic [3:0] alpha_dst_weight_reg;
    logic [1:0] rgb_equation_reg;
    logic [1:0] alpha_equation_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_enable_reg     <= 1'b0;
            write_mask_reg       <= 4'hF;
            rgb_src_weight_reg   <= WGT_ONE;
            rgb_dst_weight_reg   <= WGT_ZERO;
            alpha_src_weight_reg <= WGT_ONE;
            alpha_dst_weight_reg <= WGT_ZERO;
            rgb_equation_reg     <= EQ_ADD;
            alpha_equation_reg   <= EQ_ADD;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BLEND_ENABLE:     blend_enable_reg     <= cfg_data[0];
                REG_WRITE_MASK:       write_mask_reg       <= cfg_data;
                REG_RGB_SRC_WEIGHT:   rgb_src_weight_reg   <= cfg_data;
                REG_RGB_DST_WEIGHT:   rgb_dst_weight_reg   <= cfg_data;
                REG_ALPHA_SRC_WEIGHT: alpha_src_weight_reg <= cfg_data;
                REG_ALPHA_DST_WEIGHT: alpha_dst_weight_reg <= cfg_data;
                REG_RGB_EQUATION:     rgb_equation_reg     <= cfg_data[1:0];
                REG_ALPHA_EQUATION:   alpha_equation_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Lane settings: blending off becomes one*src + zero*dst, and the
    // saturate factor acts as one on alpha.
    lane_cfg_t rgb_cfg;
    lane_cfg_t alpha_cfg;

    always_comb begin
        if (blend_enable_reg) begin
            rgb_cfg.src_weight   = rgb_src_weight_reg;
            rgb_cfg.dst_weight   = rgb_dst_weight_reg;
            rgb_cfg.equation     = rgb_equation_reg;
            alpha_cfg.src_weight = (alpha_src_weight_reg == WGT_SRC_ALPHA_SAT) ?
                                   WGT_ONE : alpha_src_weight_reg;
            alpha_cfg.dst_weight = (alpha_dst_weight_reg == WGT_SRC_ALPHA_SAT) ?
                                   WGT_ONE : alpha_dst_weight_reg;
            alpha_cfg.equation   = alpha_equation_reg;
        end else begin
            rgb_cfg.src_weight   = WGT_ONE;
            rgb_cfg.dst_weight   = WGT_ZERO;
            rgb_cfg.equation     = EQ_ADD;
            alpha_cfg            = rgb_cfg;
        end
    end

    // Per-stage valid and ready; each stage loads when empty or draining
    logic       valid_a_reg;
    logic       valid_b_reg;
    logic       ready_a;
    logic       ready_b;
    logic       ready_c;
    lane_ctrl_t ctrl;

    assign ready_c    = !m_tvalid || m_tready;
    assign ready_b    = !valid_b_reg || ready_c;
    assign ready_a    = !valid_a_reg || ready_b;
    assign s_tready   = ready_a;
    assign ctrl       = '{adv_a: ready_a, adv_b: ready_b};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                valid_a_reg <= s_tvalid;
            end
            if (ready_b) begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    // Channel bytes in pixel order: blue, green, red, alpha
    logic [NUM_LANES*8-1:0] src_bytes;
    logic [NUM_LANES*8-1:0] dst_bytes;
    logic [NUM_LANES*8-1:0] lane_result;
    logic [NUM_LANES*8-1:0] lane_dst;

    assign src_bytes = {s_tdata[31:24], s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    assign dst_bytes = s_tdata[63:32];

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        pbr_lane u_lane (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .cfg       ((i == LANE_ALPHA) ? alpha_cfg : rgb_cfg),
            .src       (src_bytes[i*8 +: 8]),
            .dst       (dst_bytes[i*8 +: 8]),
            .src_alpha (s_tdata[31:24]),
            .dst_alpha (s_tdata[63:56]),
            .result    (lane_result[i*8 +: 8]),
            .dst_out   (lane_dst[i*8 +: 8])
        );
    end

    pbr_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (ready_c),
        .in_valid    (valid_b_reg),
        .write_mask  (write_mask_reg),
        .lane_result (lane_result),
        .lane_dst    (lane_dst),
        .out_valid   (m_tvalid),
        .out_pixel   (m_tdata)
    );

endmodule
